// ===== hdl/cat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cat_pkg: shared types and constants for the compacting array table
// Holds the word formats of both channels, the command and status codes and
// the control word that the table broadcasts to its row of storage cells.
// ----------------------------------------------------------------------------
package cat_pkg;

    localparam int DEPTH  = 8;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 8;
    localparam int CMD_W  = 3;
    localparam int POS_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_EDIT   = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4,
        CMD_FIND   = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_RANGE    = 3'd2,
        ST_FILLED   = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [IDX_W-1:0]         slot_index;
        logic signed [DATA_W-1:0] data_value;
    } t_in_word;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic [IDX_W-1:0]         found_index;
        logic [IDX_W-1:0]         element_count;
        logic                     empty_flag;
        logic                     full_flag;
    } t_out_word;

    // Control broadcast to every cell. The data field is both the value to
    // store and the value to search for.
    typedef struct packed {
        logic                     write;
        logic                     shift;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] data;
    } t_cell_ctl;

endpackage

// ===== hdl/cat_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cat_cell: one storage cell of the compacting array table
// Holds one entry, takes its upper neighbor's entry when a delete closes a
// gap at or below it, and forms its part of the first-match search chain.
// ----------------------------------------------------------------------------
module cat_cell
    import cat_pkg::*;
(
    input  logic                     i_clk,
    input  logic [POS_W-1:0]         i_cell_pos,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_filled,
    input  logic signed [DATA_W-1:0] i_next_value,
    input  logic                     i_hit_in,
    output logic                     o_hit_out,
    output logic                     o_first,
    output logic signed [DATA_W-1:0] o_value
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic                     match;

    always_comb begin
        n_value = r_value;
        if (i_ctl.write && (i_ctl.pos == i_cell_pos)) begin
            n_value = i_ctl.data;
        end else if (i_ctl.shift && (i_cell_pos >= i_ctl.pos)) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign match     = i_filled && (r_value == i_ctl.data);
    assign o_first   = match && !i_hit_in;
    assign o_hit_out = i_hit_in || match;
    assign o_value   = r_value;

endmodule

// ===== hdl/compacting_array_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_array_table: packed list of signed words with a fill count
// Decodes one command word per cycle, drives the row of storage cells and
// registers the result word for the output channel.
// ----------------------------------------------------------------------------
// The result word is registered and valid in the cycle after acceptance.
// Throughput: one command per cycle; every command, a delete with its shift
// and a find over all cells included, finishes in the single cell update.
// A new command is taken while the output register is empty or being read.
// Reset clears the fill count and the output valid; entries are not cleared
// and are never read before they are written.
module compacting_array_table
    import cat_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    t_out_word                r_out;
    t_out_word                n_out;

    logic                     in_fire;
    logic                     in_range;
    logic                     idx_filled;
    logic                     full;
    logic [POS_W-1:0]         idx_pos;
    logic [POS_W-1:0]         count_pos;
    logic                     do_write;
    logic                     do_shift;
    logic [POS_W-1:0]         sel_pos;
    t_status                  status;
    logic signed [DATA_W-1:0] rd_value;
    logic                     found;
    logic [IDX_W-1:0]         found_index;
    t_cell_ctl                ctl;

    logic signed [DATA_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]         cell_filled;
    logic [DEPTH-1:0]         cell_first;
    logic [DEPTH:0]           hit_chain;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    assign in_range   = i_in_word.slot_index < IDX_W'(DEPTH);
    assign idx_filled = i_in_word.slot_index < IDX_W'(r_count);
    assign full       = r_count == CNT_W'(DEPTH);
    assign idx_pos    = i_in_word.slot_index[POS_W-1:0];
    assign count_pos  = r_count[POS_W-1:0];

    // Row of cells; the search hit travels from position zero upward.
    assign hit_chain[0] = 1'b0;
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [DATA_W-1:0] next_value;
            if (g < DEPTH - 1) begin : g_mid
                assign next_value = cell_value[g+1];
            end else begin : g_last
                assign next_value = cell_value[g];
            end
            assign cell_filled[g] = CNT_W'(g) < r_count;
            cat_cell u_cell (
                .i_clk        (i_clk),
                .i_cell_pos   (POS_W'(g)),
                .i_ctl        (ctl),
                .i_filled     (cell_filled[g]),
                .i_next_value (next_value),
                .i_hit_in     (hit_chain[g]),
                .o_hit_out    (hit_chain[g+1]),
                .o_first      (cell_first[g]),
                .o_value      (cell_value[g])
            );
        end
    endgenerate

    always_comb begin
        found_index = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_first[i]) begin
                found_index = found_index | IDX_W'(i);
            end
        end
    end

    always_comb begin
        status   = ST_OK;
        do_write = 1'b0;
        do_shift = 1'b0;
        sel_pos  = idx_pos;
        n_count  = r_count;
        rd_value = '0;
        found    = 1'b0;
        case (t_cmd'(i_in_word.command))
            CMD_APPEND: begin
                if (full) begin
                    status = ST_OVERFLOW;
                end else begin
                    do_write = 1'b1;
                    sel_pos  = count_pos;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_INSERT: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else if (!idx_filled) begin
                    do_write = 1'b1;
                    sel_pos  = count_pos;
                    n_count  = r_count + CNT_W'(1);
                end else begin
                    status = ST_FILLED;
                end
            end
            CMD_EDIT: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else if (!idx_filled) begin
                    do_write = 1'b1;
                    sel_pos  = count_pos;
                    n_count  = r_count + CNT_W'(1);
                end else begin
                    do_write = 1'b1;
                end
            end
            CMD_DELETE: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else if (idx_filled) begin
                    do_shift = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else if (idx_filled) begin
                    rd_value = cell_value[idx_pos];
                end else begin
                    status = ST_EMPTY;
                end
            end
            CMD_FIND: begin
                found = hit_chain[DEPTH];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ctl.write = do_write && in_fire;
        ctl.shift = do_shift && in_fire;
        ctl.pos   = sel_pos;
        ctl.data  = i_in_word.data_value;
    end

    always_comb begin
        n_out.status        = status;
        n_out.read_value    = rd_value;
        n_out.found         = found;
        n_out.found_index   = found ? found_index : '0;
        n_out.element_count = IDX_W'(n_count);
        n_out.empty_flag    = n_count == '0;
        n_out.full_flag     = n_count == CNT_W'(DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count exceeds capacity");

    a_error_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && status != ST_OK) |=> r_count == $past(r_count))
        else $error("failed command changed the fill count");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && t_cmd'(i_in_word.command) == CMD_APPEND && !full)
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("append did not grow the list");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_out_valid && o_out_word.element_count == IDX_W'(r_count)))
        else $error("result word missing or count mismatch");

    a_single_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cell_first))
        else $error("more than one first match");

endmodule
